FILE: rtl/dpt_pkg.sv
// Shared types, constants and base tables for the primality test unit.
package dpt_pkg;

    localparam int NumWidthDef = 64;
    localparam int BaseWidth   = 21;

    localparam logic [63:0] Lim0 = 64'd1373653;
    localparam logic [63:0] Lim1 = 64'd9080191;
    localparam logic [63:0] Lim2 = 64'd4759123141;
    localparam logic [63:0] Lim3 = 64'd1122004669633;
    localparam logic [63:0] Lim4 = 64'd2152302898747;
    localparam logic [63:0] Lim5 = 64'd3474749660383;

    typedef enum logic [2:0] {
        BS_0, BS_1, BS_2, BS_3, BS_4, BS_5, BS_6
    } t_bset;

    typedef enum logic [1:0] {
        MS_RP, MS_PP, MS_XX
    } t_msel;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_MOD3, ST_SPLIT, ST_BASE, ST_POW_CHK, ST_POW_RW,
        ST_POW_SQ, ST_POW_PW, ST_SQ_GO, ST_SQ_W, ST_FINISH
    } t_state;

    typedef struct packed {
        logic  load;
        logic  mod3_init;
        logic  mod3_step;
        logic  split_init;
        logic  split_step;
        logic  base_init;
        logic  mul_go;
        t_msel mul_sel;
        logic  e_shift;
        logic  x_load;
        logic  sq_commit;
        logic  base_next;
        logic  res_we;
        logic  res_val;
    } t_cmd;

    typedef struct packed {
        logic lt2;
        logic le3;
        logic even;
        logic fold_done;
        logic rem_zero;
        logic d_odd;
        logic e_zero;
        logic e_lsb;
        logic mul_done;
        logic y_one;
        logic x_triv;
        logic last_sq;
        logic last_base;
    } t_stat;

    function automatic logic [BaseWidth-1:0] base_val(t_bset set, logic [3:0] idx);
        logic [BaseWidth-1:0] v;
        v = '0;
        case (set)
            BS_0: v = (idx == 4'd0) ? 21'd2 : 21'd3;
            BS_1: v = (idx == 4'd0) ? 21'd31 : 21'd73;
            BS_2: begin
                case (idx)
                    4'd0:    v = 21'd2;
                    4'd1:    v = 21'd7;
                    default: v = 21'd61;
                endcase
            end
            BS_3: begin
                case (idx)
                    4'd0:    v = 21'd2;
                    4'd1:    v = 21'd13;
                    4'd2:    v = 21'd23;
                    default: v = 21'd1662803;
                endcase
            end
            default: begin
                case (idx)
                    4'd0:    v = 21'd2;
                    4'd1:    v = 21'd3;
                    4'd2:    v = 21'd5;
                    4'd3:    v = 21'd7;
                    4'd4:    v = 21'd11;
                    4'd5:    v = 21'd13;
                    4'd6:    v = 21'd17;
                    4'd7:    v = 21'd19;
                    4'd8:    v = 21'd23;
                    4'd9:    v = 21'd29;
                    4'd10:   v = 21'd31;
                    default: v = 21'd37;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [3:0] base_last(t_bset set);
        logic [3:0] c;
        case (set)
            BS_0:    c = 4'd1;
            BS_1:    c = 4'd1;
            BS_2:    c = 4'd2;
            BS_3:    c = 4'd3;
            BS_4:    c = 4'd4;
            BS_5:    c = 4'd5;
            default: c = 4'd11;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/deterministic_primality_test_unit.sv
// Values below 4 or even are settled in the check state, multiples of three by the
// mod-3 fold. Other candidates run witness rounds, up to 12 bases for a 64-bit value;
// the bit-serial modular multiplier forms each product one multiplier bit per cycle.
// Throughput: one request at a time; busy stays high until the result strobe.
// Synchronous reset clears control only; the result is on o_is_prime in the single
// cycle o_done is high and holds until the next result is written; it cannot be stalled.
module deterministic_primality_test_unit
    import dpt_pkg::*;
#(
    parameter int NUM_WIDTH = NumWidthDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_candidate,
    output logic        o_done,
    output logic        o_is_prime
);

    t_cmd  cmd;
    t_stat stat;

    dpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    dpt_datapath #(.NUM_WIDTH(NUM_WIDTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_candidate (i_candidate),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_is_prime  (o_is_prime)
    );

endmodule

FILE: rtl/dpt_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle.
module dpt_mulmod
    import dpt_pkg::*;
#(
    parameter int NUM_WIDTH = NumWidthDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  logic [NUM_WIDTH-1:0] i_a,
    input  logic [NUM_WIDTH-1:0] i_b,
    input  logic [NUM_WIDTH-1:0] i_m,
    output logic                 o_done,
    output logic [NUM_WIDTH-1:0] o_res
);

    logic                 r_busy, n_busy;
    logic [NUM_WIDTH-1:0] r_acc, n_acc;
    logic [NUM_WIDTH-1:0] r_add, n_add;
    logic [NUM_WIDTH-1:0] r_mult, n_mult;
    logic [NUM_WIDTH:0]   sum_acc, sum_add;

    assign sum_acc = {1'b0, r_acc} + {1'b0, r_add};
    assign sum_add = {1'b0, r_add} + {1'b0, r_add};
    assign o_done  = r_busy && (r_mult == '0);
    assign o_res   = r_acc;

    always_comb begin
        n_busy = r_busy;
        n_acc  = r_acc;
        n_add  = r_add;
        n_mult = r_mult;
        if (i_go) begin
            n_busy = 1'b1;
            n_acc  = '0;
            n_add  = i_b;
            n_mult = i_a;
        end else if (r_busy) begin
            if (r_mult == '0) begin
                n_busy = 1'b0;
            end else begin
                if (r_mult[0]) begin
                    n_acc = (sum_acc >= {1'b0, i_m}) ? NUM_WIDTH'(sum_acc - {1'b0, i_m})
                                                     : NUM_WIDTH'(sum_acc);
                end
                n_add  = (sum_add >= {1'b0, i_m}) ? NUM_WIDTH'(sum_add - {1'b0, i_m})
                                                  : NUM_WIDTH'(sum_add);
                n_mult = r_mult >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_acc  <= n_acc;
        r_add  <= n_add;
        r_mult <= n_mult;
    end

    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !i_go |=> !r_busy) else $error("multiplier stays busy after done");
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && (r_mult != '0) |=> r_busy) else $error("multiplier stopped early");
    a_acc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !$past(i_go) && $past(r_busy) |-> r_acc < i_m)
        else $error("accumulator out of range");

endmodule

FILE: rtl/dpt_datapath.sv
// Datapath: candidate, exponent split, modular power and squaring registers.
module dpt_datapath
    import dpt_pkg::*;
#(
    parameter int NUM_WIDTH = NumWidthDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [63:0] i_candidate,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_is_prime
);

    localparam int SW = $clog2(NUM_WIDTH) + 1;

    logic [NUM_WIDTH-1:0] r_n, r_d, r_r, r_p, r_e, r_x;
    logic [SW-1:0]        r_s, r_i;
    t_bset                r_set;
    logic [3:0]           r_idx;
    t_msel                r_msel;
    logic                 r_res;

    logic [NUM_WIDTH-1:0] mul_a, mul_b, mul_res;
    logic                 mul_done;
    logic [63:0]          n_ext;
    t_bset                set_sel;
    logic [NUM_WIDTH-1:0] n_fold;

    assign n_ext = 64'(r_n);

    // 2^8 and 2^2 are both 1 mod 3: fold bytes while wide, then bit pairs
    assign n_fold = (r_d[NUM_WIDTH-1:8] != '0) ? (r_d >> 8) + NUM_WIDTH'(r_d[7:0])
                                               : (r_d >> 2) + NUM_WIDTH'(r_d[1:0]);

    always_comb begin
        if (n_ext < Lim0)      set_sel = BS_0;
        else if (n_ext < Lim1) set_sel = BS_1;
        else if (n_ext < Lim2) set_sel = BS_2;
        else if (n_ext < Lim3) set_sel = BS_3;
        else if (n_ext < Lim4) set_sel = BS_4;
        else if (n_ext < Lim5) set_sel = BS_5;
        else                   set_sel = BS_6;
    end

    always_comb begin
        case (i_cmd.mul_sel)
            MS_RP: begin
                mul_a = r_r;
                mul_b = r_p;
            end
            MS_PP: begin
                mul_a = r_p;
                mul_b = r_p;
            end
            default: begin
                mul_a = r_x;
                mul_b = r_x;
            end
        endcase
    end

    dpt_mulmod #(.NUM_WIDTH(NUM_WIDTH)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.mul_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_m     (r_n),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n <= i_candidate[NUM_WIDTH-1:0];
        end
        if (i_cmd.mod3_init) begin
            r_d <= r_n;
        end
        if (i_cmd.mod3_step) begin
            r_d <= n_fold;
        end
        if (i_cmd.split_init) begin
            r_d   <= r_n >> 1;
            r_s   <= SW'(1);
            r_set <= set_sel;
            r_idx <= 4'd0;
        end
        if (i_cmd.split_step) begin
            r_d <= r_d >> 1;
            r_s <= r_s + 1'b1;
        end
        if (i_cmd.base_init) begin
            r_r <= NUM_WIDTH'(1);
            r_p <= {{(NUM_WIDTH-BaseWidth){1'b0}}, base_val(r_set, r_idx)};
            r_e <= r_d;
        end
        if (i_cmd.mul_go) begin
            r_msel <= i_cmd.mul_sel;
        end
        if (mul_done) begin
            case (r_msel)
                MS_RP:   r_r <= mul_res;
                MS_PP:   r_p <= mul_res;
                default: ;
            endcase
        end
        if (i_cmd.e_shift) begin
            r_e <= r_e >> 1;
        end
        if (i_cmd.x_load) begin
            r_x <= r_r;
            r_i <= '0;
        end
        if (i_cmd.sq_commit) begin
            r_x <= mul_res;
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.base_next) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.res_we) begin
            r_res <= i_cmd.res_val;
        end
    end

    assign o_stat.lt2       = (r_n < NUM_WIDTH'(2));
    assign o_stat.le3       = (r_n <= NUM_WIDTH'(3));
    assign o_stat.even      = !r_n[0];
    assign o_stat.fold_done = (r_d[NUM_WIDTH-1:2] == '0);
    // a nonzero multiple of three folds down to exactly 3
    assign o_stat.rem_zero  = (r_d[1:0] == 2'd3);
    assign o_stat.d_odd     = r_d[0];
    assign o_stat.e_zero    = (r_e == '0);
    assign o_stat.e_lsb     = r_e[0];
    assign o_stat.mul_done  = mul_done;
    assign o_stat.y_one     = (mul_res == NUM_WIDTH'(1));
    assign o_stat.x_triv    = (r_x == NUM_WIDTH'(1)) || (r_x == r_n - 1'b1);
    assign o_stat.last_sq   = (r_i == r_s - 1'b1);
    assign o_stat.last_base = (r_idx == base_last(r_set));
    assign o_is_prime       = r_res;

endmodule

FILE: rtl/dpt_ctrl.sv
// Controller: sequences trial checks, exponent split and witness rounds.
module dpt_ctrl
    import dpt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_done
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (i_start) n_state = ST_CHECK;
            ST_CHECK: begin
                if (i_stat.lt2 || i_stat.le3 || i_stat.even) n_state = ST_FINISH;
                else n_state = ST_MOD3;
            end
            ST_MOD3: begin
                if (i_stat.fold_done) n_state = i_stat.rem_zero ? ST_FINISH : ST_SPLIT;
            end
            ST_SPLIT:   if (i_stat.d_odd) n_state = ST_BASE;
            ST_BASE:    n_state = ST_POW_CHK;
            ST_POW_CHK: begin
                if (i_stat.e_zero) n_state = ST_SQ_GO;
                else if (i_stat.e_lsb) n_state = ST_POW_RW;
                else n_state = ST_POW_SQ;
            end
            ST_POW_RW:  if (i_stat.mul_done) n_state = ST_POW_SQ;
            ST_POW_SQ:  n_state = ST_POW_PW;
            ST_POW_PW:  if (i_stat.mul_done) n_state = ST_POW_CHK;
            ST_SQ_GO:   n_state = ST_SQ_W;
            ST_SQ_W: begin
                if (i_stat.mul_done) begin
                    if (i_stat.y_one && !i_stat.x_triv) n_state = ST_FINISH;
                    else if (i_stat.last_sq) begin
                        if (!i_stat.y_one || i_stat.last_base) n_state = ST_FINISH;
                        else n_state = ST_BASE;
                    end else n_state = ST_SQ_GO;
                end
            end
            ST_FINISH:  n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = MS_RP;
        o_busy        = (r_state != ST_IDLE);
        o_done        = (r_state == ST_FINISH);
        case (r_state)
            ST_IDLE: o_cmd.load = i_start;
            ST_CHECK: begin
                if (i_stat.lt2) begin
                    o_cmd.res_we = 1'b1;
                end else if (i_stat.le3) begin
                    o_cmd.res_we  = 1'b1;
                    o_cmd.res_val = 1'b1;
                end else if (i_stat.even) begin
                    o_cmd.res_we = 1'b1;
                end else begin
                    o_cmd.mod3_init = 1'b1;
                end
            end
            ST_MOD3: begin
                if (!i_stat.fold_done) o_cmd.mod3_step = 1'b1;
                else if (i_stat.rem_zero) o_cmd.res_we = 1'b1;
                else o_cmd.split_init = 1'b1;
            end
            ST_SPLIT:   o_cmd.split_step = !i_stat.d_odd;
            ST_BASE:    o_cmd.base_init = 1'b1;
            ST_POW_CHK: begin
                if (i_stat.e_zero) o_cmd.x_load = 1'b1;
                else if (i_stat.e_lsb) o_cmd.mul_go = 1'b1;
            end
            ST_POW_SQ: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MS_PP;
            end
            ST_POW_PW:  o_cmd.e_shift = i_stat.mul_done;
            ST_SQ_GO: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MS_XX;
            end
            ST_SQ_W: begin
                if (i_stat.mul_done) begin
                    if (i_stat.y_one && !i_stat.x_triv) begin
                        o_cmd.res_we = 1'b1;
                    end else if (i_stat.last_sq) begin
                        if (!i_stat.y_one) begin
                            o_cmd.res_we = 1'b1;
                        end else if (i_stat.last_base) begin
                            o_cmd.res_we  = 1'b1;
                            o_cmd.res_val = 1'b1;
                        end else begin
                            o_cmd.base_next = 1'b1;
                        end
                    end else begin
                        o_cmd.sq_commit = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy) else $error("done outside a request");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done longer than one cycle");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy && !o_done) else $error("request not taken");
    a_result_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_we |=> o_done) else $error("result written without finishing");

endmodule
